/* sv/gbc_pkg.sv */
// Package for the glyph bounding-box centering unit: sizes, request and
// register codes, and the controller/datapath command and status words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

  // Geometry
  localparam int CANVAS_ROWS = 32;
  localparam int CANVAS_COLS = 128;
  localparam int IMAGE_SIDE  = 28;
  localparam int CANVAS_SIZE = CANVAS_ROWS * CANVAS_COLS;
  localparam int IMAGE_SIZE  = IMAGE_SIDE * IMAGE_SIDE;

  // Field widths
  localparam int TYPE_W  = 2;
  localparam int PROW_W  = 5;
  localparam int CW      = 7;   // span / pixel column field
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 10;
  localparam int LIMIT_W = 7;
  localparam int NOISE_W = 13;
  localparam int CFG_W   = 13;  // widest register
  localparam int CFGI_W  = 1;

  // Derived widths
  localparam int RW     = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int CA_W   = $clog2(CANVAS_SIZE);
  localparam int IA_W   = $clog2(IMAGE_SIZE);
  localparam int IS_W   = $clog2(IMAGE_SIDE);
  localparam int SD_W   = $clog2(IMAGE_SIDE + 1);
  localparam int SWEEP_N = (CANVAS_SIZE > IMAGE_SIZE) ? CANVAS_SIZE : IMAGE_SIZE;
  localparam int SW_W   = $clog2(SWEEP_N);
  localparam int CNT_W  = $clog2(CANVAS_ROWS * (1 << CW) + 1);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_CLEAR   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PROCESS = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_READ    = 2'd3;

  // Register indexes and reset values
  localparam logic [CFGI_W-1:0]  CFG_NARROW   = 1'd0;
  localparam logic [CFGI_W-1:0]  CFG_NOISE    = 1'd1;
  localparam logic [LIMIT_W-1:0] NARROW_RESET = 7'd3;
  localparam logic [NOISE_W-1:0] NOISE_RESET  = 13'd10;

  typedef struct packed {
    logic load;          // latch the request word
    logic sweep_canvas;  // write zero at sweep count
    logic sweep_image;
    logic pix_write;
    logic scan_rst;      // rewind span walk to first column, row 0
    logic scan_step;
    logic copy_mode;     // walk copies into image instead of counting
    logic set_accept;
    logic set_bad;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              bad_order;
    logic              sweep_canvas_last;
    logic              sweep_image_last;
    logic              sweep_all_last;
    logic              scan_last;
    logic              reject;
    logic              found;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/glyph_bbox_centering_unit.sv */
// Glyph bounding-box centering unit, top level. Uses gbc_pkg, gbc_ctrl,
// gbc_datapath (which holds the canvas and image RAMs).
// Write and read requests go straight to done; a canvas clear sweeps the
// canvas first. A process request with start>end ends at once with bad_range;
// else it runs the count pass, then, when kept, clears the image and, when
// the span holds a nonzero pixel, runs the copy pass.
// One request at a time; done pulses one cycle and cannot be stalled.
// After rst a clearing pass zeros both RAMs, busy high.
`timescale 1ns / 1ps
`default_nettype none

module glyph_bbox_centering_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command handshake
  input  wire logic                       start,
  output logic                            busy,
  output logic                            done,
  // config write port
  input  wire logic                       cfg_we,
  input  wire logic [gbc_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [gbc_pkg::CFG_W-1:0]  cfg_data,
  // request word
  input  wire logic [gbc_pkg::TYPE_W-1:0] req_type,
  input  wire logic [gbc_pkg::PROW_W-1:0] pixel_row,
  input  wire logic [gbc_pkg::CW-1:0]     pixel_column,
  input  wire logic [gbc_pkg::PIX_W-1:0]  pixel_value,
  input  wire logic [gbc_pkg::CW-1:0]     start_column,
  input  wire logic [gbc_pkg::CW-1:0]     end_column,
  input  wire logic [gbc_pkg::IDX_W-1:0]  image_index,
  // result word, valid while done is high
  output logic                            accepted,
  output logic                            bad_range,
  output logic      [gbc_pkg::PIX_W-1:0]  read_value
);
  import gbc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: owns busy/done and drives the datapath commands
  gbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // Storage and arithmetic
  gbc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .pixel_value  (pixel_value),
    .start_column (start_column),
    .end_column   (end_column),
    .image_index  (image_index),
    .accepted     (accepted),
    .bad_range    (bad_range),
    .read_value   (read_value)
  );

  // A start in idle always makes the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Done is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // A misordered span never reports an image
  a_bad_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (done && bad_range) |-> !accepted)
    else $error("bad_range with accepted");

endmodule

`default_nettype wire

/* sv/gbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/gbc_datapath.sv */
// Datapath: config registers, canvas and image RAMs, sweep counter,
// span walk, pixel count / row bounds, centered copy. Uses gbc_pkg, gbc_ram.
`timescale 1ns / 1ps
`default_nettype none

module gbc_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gbc_pkg::ctrl_cmd_t         cmd,
  output gbc_pkg::dp_status_t             status,
  input  wire logic                       cfg_we,
  input  wire logic [gbc_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [gbc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [gbc_pkg::TYPE_W-1:0] req_type,
  input  wire logic [gbc_pkg::PROW_W-1:0] pixel_row,
  input  wire logic [gbc_pkg::CW-1:0]     pixel_column,
  input  wire logic [gbc_pkg::PIX_W-1:0]  pixel_value,
  input  wire logic [gbc_pkg::CW-1:0]     start_column,
  input  wire logic [gbc_pkg::CW-1:0]     end_column,
  input  wire logic [gbc_pkg::IDX_W-1:0]  image_index,
  output logic                            accepted,
  output logic                            bad_range,
  output logic      [gbc_pkg::PIX_W-1:0]  read_value
);
  import gbc_pkg::*;

  localparam int HW_W = ((CW + 1) > SD_W) ? (CW + 1) : SD_W;
  localparam int VH_W = ((RW + 1) > SD_W) ? (RW + 1) : SD_W;
  localparam int TC_W = ((CW > IS_W) ? CW : IS_W) + 1;
  localparam int TR_W = ((RW > IS_W) ? RW : IS_W) + 1;
  localparam int CMP_W = (CNT_W > NOISE_W) ? CNT_W : NOISE_W;

  // Config
  logic [LIMIT_W-1:0] narrow_limit;
  logic [NOISE_W-1:0] noise_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_limit <= NARROW_RESET;
      noise_min    <= NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NARROW: narrow_limit <= cfg_data[LIMIT_W-1:0];
        CFG_NOISE:  noise_min    <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched request word
  logic [TYPE_W-1:0] req_t;
  logic [PROW_W-1:0] pix_row;
  logic [CW-1:0]     pix_col;
  logic [PIX_W-1:0]  pix_val;
  logic [CW-1:0]     span_first;
  logic [CW-1:0]     span_last;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_t      <= req_type;
      pix_row    <= pixel_row;
      pix_col    <= pixel_column;
      pix_val    <= pixel_value;
      span_first <= start_column;
      span_last  <= end_column;
      rd_idx     <= image_index;
      rd_sel     <= (req_type == REQ_READ) && (32'(image_index) < IMAGE_SIZE);
    end
  end

  // Sweep counter, idles at zero
  logic [SW_W-1:0] sweep_cnt;
  logic            sweeping;
  assign sweeping = cmd.sweep_canvas || cmd.sweep_image;

  always_ff @(posedge clk) begin
    if (rst || !sweeping) begin
      sweep_cnt <= '0;
    end else begin
      sweep_cnt <= sweep_cnt + SW_W'(1);
    end
  end

  // Span walk: column-major, rows 0..CANVAS_ROWS-1 per column
  logic [CW-1:0] scan_col;
  logic [RW-1:0] scan_row;
  logic          row_wrap;
  assign row_wrap = (scan_row == RW'(CANVAS_ROWS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_col <= start_column;
      scan_row <= '0;
    end else if (cmd.scan_rst) begin
      scan_col <= span_first;
      scan_row <= '0;
    end else if (cmd.scan_step) begin
      if (row_wrap) begin
        scan_row <= '0;
        scan_col <= scan_col + CW'(1);
      end else begin
        scan_row <= scan_row + RW'(1);
      end
    end
  end

  // Read-stage tags for the registered canvas read
  logic          vld_d;
  logic          copy_d;
  logic          colok_d;
  logic [CW-1:0] col_d;
  logic [RW-1:0] row_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else begin
      vld_d <= cmd.scan_step;
    end
    copy_d  <= cmd.copy_mode;
    colok_d <= (32'(scan_col) < CANVAS_COLS);
    col_d   <= scan_col;
    row_d   <= scan_row;
  end

  // Canvas RAM
  logic            cv_we;
  logic [CA_W-1:0] cv_waddr;
  logic [PIX_W-1:0] cv_wdata;
  logic [CA_W-1:0] cv_raddr;
  logic [PIX_W-1:0] cv_rdata;

  always_comb begin
    cv_we    = 1'b0;
    cv_waddr = CA_W'(pix_row) * CA_W'(CANVAS_COLS) + CA_W'(pix_col);
    cv_wdata = pix_val;
    if (cmd.sweep_canvas) begin
      cv_we    = (32'(sweep_cnt) < CANVAS_SIZE);
      cv_waddr = sweep_cnt[CA_W-1:0];
      cv_wdata = '0;
    end else if (cmd.pix_write) begin
      cv_we = (32'(pix_row) < CANVAS_ROWS) && (32'(pix_col) < CANVAS_COLS);
    end
  end

  assign cv_raddr = CA_W'(scan_row) * CA_W'(CANVAS_COLS) + CA_W'(scan_col);

  gbc_ram #(.WIDTH(PIX_W), .DEPTH(CANVAS_SIZE)) u_canvas (
    .clk   (clk),
    .we    (cv_we),
    .waddr (cv_waddr),
    .wdata (cv_wdata),
    .raddr (cv_raddr),
    .rdata (cv_rdata)
  );

  logic pix_nz;
  assign pix_nz = vld_d && colok_d && (cv_rdata != '0);

  // Count and row bounds of nonzero pixels
  logic [CNT_W-1:0] count;
  logic             found;
  logic [RW-1:0]    top;
  logic [RW-1:0]    bot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= '0;
      found <= 1'b0;
    end else if (pix_nz && !copy_d) begin
      count <= count + CNT_W'(1);
      found <= 1'b1;
      top   <= (!found || row_d < top) ? row_d : top;
      bot   <= (!found || row_d > bot) ? row_d : bot;
    end
  end

  // Centering offsets
  logic [HW_W-1:0] span_width;
  logic [VH_W-1:0] box_height;
  logic [IS_W-1:0] hoff;
  logic [IS_W-1:0] voff;

  always_comb begin
    span_width = HW_W'(span_last) - HW_W'(span_first) + HW_W'(1);
    box_height = VH_W'(bot) - VH_W'(top) + VH_W'(1);
    hoff = (span_width <= HW_W'(IMAGE_SIDE))
           ? IS_W'((HW_W'(IMAGE_SIDE) - span_width) >> 1) : '0;
    voff = (box_height <= VH_W'(IMAGE_SIDE))
           ? IS_W'((VH_W'(IMAGE_SIDE) - box_height) >> 1) : '0;
  end

  // Target position of the pixel in the read stage
  logic [TC_W-1:0] tc;
  logic [TR_W-1:0] tr;
  logic [IS_W-1:0] tr_clamp;

  always_comb begin
    tc = TC_W'(col_d - span_first) + TC_W'(hoff);
    tr = TR_W'(row_d - top) + TR_W'(voff);
    tr_clamp = (tr >= TR_W'(IMAGE_SIDE)) ? IS_W'(IMAGE_SIDE - 1) : tr[IS_W-1:0];
  end

  // Image RAM
  logic            im_we;
  logic [IA_W-1:0] im_waddr;
  logic [PIX_W-1:0] im_wdata;
  logic [PIX_W-1:0] im_rdata;

  always_comb begin
    if (cmd.sweep_image) begin
      im_we    = (32'(sweep_cnt) < IMAGE_SIZE);
      im_waddr = IA_W'(sweep_cnt);
      im_wdata = '0;
    end else begin
      im_we    = pix_nz && copy_d && (tc < TC_W'(IMAGE_SIDE));
      im_waddr = IA_W'(tr_clamp) * IA_W'(IMAGE_SIDE) + IA_W'(tc);
      im_wdata = cv_rdata;
    end
  end

  gbc_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_SIZE)) u_image (
    .clk   (clk),
    .we    (im_we),
    .waddr (im_waddr),
    .wdata (im_wdata),
    .raddr (IA_W'(rd_idx)),
    .rdata (im_rdata)
  );

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accepted  <= 1'b0;
      bad_range <= 1'b0;
    end else begin
      if (cmd.set_accept) accepted  <= 1'b1;
      if (cmd.set_bad)    bad_range <= 1'b1;
    end
  end

  assign read_value = rd_sel ? im_rdata : '0;

  // Status
  always_comb begin
    status.req_type          = req_t;
    status.bad_order         = (span_first > span_last);
    status.sweep_canvas_last = (32'(sweep_cnt) == CANVAS_SIZE - 1);
    status.sweep_image_last  = (32'(sweep_cnt) == IMAGE_SIZE - 1);
    status.sweep_all_last    = (32'(sweep_cnt) == SWEEP_N - 1);
    status.scan_last         = (scan_col == span_last) && row_wrap;
    status.reject            = ((span_last - span_first) <= narrow_limit)
                               && (CMP_W'(count) < CMP_W'(noise_min));
    status.found             = found;
  end

endmodule

`default_nettype wire

/* sv/gbc_ctrl.sv */
// Controller state machine: sequences clears, writes, reads and the two
// span walks of a process request. Uses gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output logic                     done,
  output gbc_pkg::ctrl_cmd_t       cmd,
  input  wire gbc_pkg::dp_status_t status
);
  import gbc_pkg::*;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_CLRC     = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_SCAN_END = 4'd5;
  localparam logic [3:0] S_DECIDE   = 4'd6;
  localparam logic [3:0] S_CLRI     = 4'd7;
  localparam logic [3:0] S_COPY     = 4'd8;
  localparam logic [3:0] S_COPY_END = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.sweep_canvas = 1'b1;
        cmd.sweep_image  = 1'b1;
        if (status.sweep_all_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.req_type)
          REQ_CLEAR: state_next = S_CLRC;
          REQ_WRITE: begin
            cmd.pix_write = 1'b1;
            state_next    = S_DONE;
          end
          REQ_PROCESS: begin
            if (status.bad_order) begin
              cmd.set_bad = 1'b1;
              state_next  = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: state_next = S_DONE;  // read: image RAM addressed now
        endcase
      end
      S_CLRC: begin
        cmd.sweep_canvas = 1'b1;
        if (status.sweep_canvas_last) state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.reject) begin
          state_next = S_DONE;
        end else begin
          cmd.set_accept = 1'b1;
          cmd.scan_rst   = 1'b1;
          state_next     = S_CLRI;
        end
      end
      S_CLRI: begin
        cmd.sweep_image = 1'b1;
        if (status.sweep_image_last) state_next = status.found ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.scan_step = 1'b1;
        cmd.copy_mode = 1'b1;
        if (status.scan_last) state_next = S_COPY_END;
      end
      S_COPY_END: state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == S_IDLE))
    else $error("done not followed by idle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE) && start)
    else $error("request latched outside idle");

  a_copy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) && $past(state) != S_COPY |-> $past(state) == S_CLRI)
    else $error("copy entered without image clear");

endmodule

`default_nettype wire

/* tb/glyph_bbox_centering_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for glyph_bbox_centering_unit: directed corner words, then
// random glyph sequences under several register settings, checked by a local model.
// Depends on gbc_pkg and the unit RTL.

module glyph_bbox_centering_unit_tb;
  import gbc_pkg::*;

  // Longest quiet stretch of a correct run is a full-width process word;
  // the post-reset clearing pass is shorter.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PRINT_CAP      = 40;
  localparam int PHASE_WORDS    = 190;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [PROW_W-1:0] row;
    logic [CW-1:0]     col;
    logic [PIX_W-1:0]  value;
    logic [CW-1:0]     first_col;
    logic [CW-1:0]     last_col;
    logic [IDX_W-1:0]  index;
  } glyph_req_t;

  typedef struct packed {
    logic             accepted;
    logic             bad_range;
    logic [PIX_W-1:0] read_value;
  } glyph_res_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               done;
  logic               cfg_we;
  logic [CFGI_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic [TYPE_W-1:0]  req_type;
  logic [PROW_W-1:0]  pixel_row;
  logic [CW-1:0]      pixel_column;
  logic [PIX_W-1:0]   pixel_value;
  logic [CW-1:0]      start_column;
  logic [CW-1:0]      end_column;
  logic [IDX_W-1:0]   image_index;
  logic               accepted;
  logic               bad_range;
  logic [PIX_W-1:0]   read_value;

  glyph_bbox_centering_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .pixel_value  (pixel_value),
    .start_column (start_column),
    .end_column   (end_column),
    .image_index  (image_index),
    .accepted     (accepted),
    .bad_range    (bad_range),
    .read_value   (read_value)
  );

  // ---------------------------------------------------------------------
  // Local model state: canvas, centered image, and the two registers.
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0]   canvas_model [CANVAS_SIZE];
  logic [PIX_W-1:0]   image_model  [IMAGE_SIZE];
  logic [LIMIT_W-1:0] narrow_limit;
  logic [NOISE_W-1:0] noise_floor;

  glyph_res_t pending_results [$];
  glyph_res_t oldest;
  int         error_count;
  int         results_seen;
  int         words_sent;
  int         gap_pct;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] canvas_px(int row, int col);
    if (row >= CANVAS_ROWS || col >= CANVAS_COLS) return '0;
    return canvas_model[row * CANVAS_COLS + col];
  endfunction

  // Noise check, then copy the span centered: horizontally on span width,
  // vertically on the row bounding box of its nonzero pixels.
  function automatic glyph_res_t center_span(int first, int last);
    glyph_res_t       res;
    int               count, top, bottom, hoff, voff, tc, tr, span_w, box_h;
    bit               found;
    logic [PIX_W-1:0] px;
    res = '0;
    count = 0;
    top = 0;
    bottom = 0;
    found = 1'b0;
    if (first > last) begin
      res.bad_range = 1'b1;
      return res;
    end
    if (last - first <= int'(narrow_limit)) begin
      for (int c = first; c <= last; c++)
        for (int r = 0; r < CANVAS_ROWS; r++)
          if (canvas_px(r, c) != 0) count++;
      if (count < int'(noise_floor)) return res;
    end
    foreach (image_model[i]) image_model[i] = '0;
    res.accepted = 1'b1;
    for (int r = 0; r < CANVAS_ROWS; r++)
      for (int c = first; c <= last; c++)
        if (canvas_px(r, c) != 0) begin
          if (!found) begin
            top = r;
            found = 1'b1;
          end
          bottom = r;
        end
    if (!found) return res;
    span_w = last - first + 1;
    box_h  = bottom - top + 1;
    hoff = (span_w <= IMAGE_SIDE) ? (IMAGE_SIDE - span_w) / 2 : 0;
    voff = (box_h <= IMAGE_SIDE) ? (IMAGE_SIDE - box_h) / 2 : 0;
    // column order, top to bottom: later pixels win on collisions
    for (int c = first; c <= last; c++) begin
      tc = c - first + hoff;
      if (tc < IMAGE_SIDE) begin
        for (int r = 0; r < CANVAS_ROWS; r++) begin
          px = canvas_px(r, c);
          if (px != 0) begin
            tr = r - top + voff;
            if (tr >= IMAGE_SIDE) tr = IMAGE_SIDE - 1;
            image_model[tr * IMAGE_SIDE + tc] = px;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic glyph_res_t predict_centering(glyph_req_t q);
    glyph_res_t res;
    res = '0;
    case (q.kind)
      REQ_CLEAR: begin
        foreach (canvas_model[i]) canvas_model[i] = '0;
      end
      REQ_WRITE: begin
        if (int'(q.row) < CANVAS_ROWS && int'(q.col) < CANVAS_COLS)
          canvas_model[int'(q.row) * CANVAS_COLS + int'(q.col)] = q.value;
      end
      REQ_PROCESS: begin
        res = center_span(int'(q.first_col), int'(q.last_col));
      end
      default: begin
        if (int'(q.index) < IMAGE_SIZE) res.read_value = image_model[q.index];
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every done is compared against the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int exp);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("MISMATCH word %0d %s: got %0d expected %0d", results_seen, what, got, exp);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("done with nothing outstanding", 1, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (accepted !== oldest.accepted)
          report_mismatch("accepted", accepted, oldest.accepted);
        if (bad_range !== oldest.bad_range)
          report_mismatch("bad_range", bad_range, oldest.bad_range);
        if (read_value !== oldest.read_value)
          report_mismatch("read_value", read_value, oldest.read_value);
      end
      results_seen++;
    end
  end

  // Watchdog: cycles with neither an accepted word nor a done.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("glyph_bbox_centering_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  function automatic glyph_req_t random_word();
    glyph_req_t q;
    q.kind      = TYPE_W'($urandom);
    q.row       = PROW_W'($urandom);
    q.col       = CW'($urandom);
    q.value     = PIX_W'($urandom);
    q.first_col = CW'($urandom);
    q.last_col  = CW'($urandom);
    q.index     = IDX_W'($urandom);
    return q;
  endfunction

  // Present one word, hold start until it is taken, then predict it.
  // start is left high so a following word goes back to back.
  task automatic send_word(glyph_req_t q);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    req_type     <= q.kind;
    pixel_row    <= q.row;
    pixel_column <= q.col;
    pixel_value  <= q.value;
    start_column <= q.first_col;
    end_column   <= q.last_col;
    image_index  <= q.index;
    start        <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_centering(q));
    words_sent++;
  endtask

  task automatic clear_canvas();
    glyph_req_t q;
    q = random_word();
    q.kind = REQ_CLEAR;
    send_word(q);
  endtask

  task automatic put_pixel(int row, int col, int value);
    glyph_req_t q;
    q = random_word();
    q.kind  = REQ_WRITE;
    q.row   = PROW_W'(row);
    q.col   = CW'(col);
    q.value = PIX_W'(value);
    send_word(q);
  endtask

  task automatic process_span(int first, int last);
    glyph_req_t q;
    q = random_word();
    q.kind      = REQ_PROCESS;
    q.first_col = CW'(first);
    q.last_col  = CW'(last);
    send_word(q);
  endtask

  task automatic read_pixel(int index);
    glyph_req_t q;
    q = random_word();
    q.kind  = REQ_READ;
    q.index = IDX_W'(index);
    send_word(q);
  endtask

  // Drop start and wait until the unit is quiet with nothing outstanding.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
    repeat (2) @(posedge clk);
  endtask

  // Both registers, back to back; only called from an idle unit.
  task automatic apply_settings(int narrow, int noise);
    cfg_index <= CFG_NARROW;
    cfg_data  <= CFG_W'(narrow);
    cfg_we    <= 1'b1;
    @(posedge clk);
    narrow_limit = LIMIT_W'(narrow);
    cfg_index <= CFG_NOISE;
    cfg_data  <= CFG_W'(noise);
    @(posedge clk);
    noise_floor = NOISE_W'(noise);
    cfg_we <= 1'b0;
  endtask

  // Draw a glyph into a column band, process a span around it, read back.
  task automatic glyph_sequence();
    int w, c0, r0, r1, first, last, pick;
    int hits [$];
    if ($urandom_range(7, 0) == 0) clear_canvas();
    w  = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
    c0 = $urandom_range(CANVAS_COLS - w, 0);
    if ($urandom_range(4, 0) == 0) begin
      r0 = 0;
      r1 = CANVAS_ROWS - 1;
    end else begin
      r0 = $urandom_range(CANVAS_ROWS - 1, 0);
      r1 = $urandom_range(CANVAS_ROWS - 1, r0);
    end
    repeat ($urandom_range(24, 1))
      put_pixel($urandom_range(r1, r0), $urandom_range(c0 + w - 1, c0),
                ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(255, 1));
    first = c0;
    last  = c0 + w - 1;
    case ($urandom_range(11, 0))
      0: begin
        first = $urandom_range(CANVAS_COLS - 1, 1);
        last  = $urandom_range(first - 1, 0);
      end
      1: begin
        first = 0;
        last  = CANVAS_COLS - 1;
      end
      2, 3: begin
        first = (c0 > 3) ? c0 - $urandom_range(3, 0) : 0;
        last  = (last + 3 < CANVAS_COLS) ? last + $urandom_range(3, 0) : last;
      end
      default: ;
    endcase
    process_span(first, last);
    // sometimes hold off until everything so far has come back
    if ($urandom_range(7, 0) == 0) wait_idle();
    foreach (image_model[i]) if (image_model[i] != 0) hits.push_back(i);
    repeat ($urandom_range(12, 3)) begin
      if (hits.size() != 0 && $urandom_range(1, 0) == 1) begin
        pick = hits[$urandom_range(hits.size() - 1, 0)];
        read_pixel(pick);
      end else begin
        read_pixel($urandom_range((1 << IDX_W) - 1, 0));
      end
    end
  endtask

  // Unstructured words; canvas clears are thinned out since each sweeps the whole canvas.
  task automatic noise_burst();
    glyph_req_t q;
    repeat ($urandom_range(6, 1)) begin
      q = random_word();
      if (q.kind == REQ_CLEAR && $urandom_range(3, 0) != 0) q.kind = REQ_READ;
      send_word(q);
    end
  endtask

  task automatic random_phase(int narrow, int noise, int idle_pct);
    int base;
    wait_idle();
    apply_settings(narrow, noise);
    gap_pct = idle_pct;
    base = words_sent;
    while (words_sent - base < PHASE_WORDS) begin
      if ($urandom_range(9, 0) < 3) noise_burst();
      else glyph_sequence();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset register values; field extremes, every request code, edge cases.
  task automatic test_directed_corners();
    gap_pct = 0;
    read_pixel(0);
    read_pixel(IMAGE_SIZE - 1);
    read_pixel((1 << IDX_W) - 1);                 // index past the image
    process_span(CANVAS_COLS - 1, 0);             // start after end
    process_span(10, 12);                         // narrow and empty: noise
    process_span(0, CANVAS_COLS - 1);             // empty wide span, kept
    put_pixel(0, 0, 255);
    put_pixel(CANVAS_ROWS - 1, CANVAS_COLS - 1, 1);  // column past image
    put_pixel(29, 1, 8'h55);                      // rows past image clamp and collide
    put_pixel(30, 1, 8'hAA);
    put_pixel(31, 1, 8'h0F);
    put_pixel(15, 64, 8'h80);
    process_span(0, CANVAS_COLS - 1);             // wide span, tall box
    read_pixel(0);
    read_pixel((IMAGE_SIDE - 1) * IMAGE_SIDE + 1);
    read_pixel(IMAGE_SIZE - 1);
    process_span(1, 1);                           // narrow, too few pixels
    put_pixel(0, 1, 0);
    clear_canvas();
    process_span(0, CANVAS_COLS - 1);
    read_pixel(0);
    read_pixel((IMAGE_SIDE - 1) * IMAGE_SIDE + 1);
  endtask

  task automatic test_random_light_idle();
    random_phase(NARROW_RESET, NOISE_RESET, 7);
    random_phase(0, 0, 7);
  endtask

  task automatic test_random_heavy_idle();
    random_phase((1 << LIMIT_W) - 1, 4096, 48);   // every narrow span rejected
    random_phase(8, 6, 48);
  endtask

  task automatic test_random_back_to_back();
    random_phase((1 << LIMIT_W) - 1, 1, 0);
    random_phase(2, 4095, 0);
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_NARROW;
    cfg_data     <= '0;
    req_type     <= REQ_READ;
    pixel_row    <= '0;
    pixel_column <= '0;
    pixel_value  <= '0;
    start_column <= '0;
    end_column   <= '0;
    image_index  <= '0;
    foreach (canvas_model[i]) canvas_model[i] = '0;
    foreach (image_model[i]) image_model[i] = '0;
    narrow_limit = NARROW_RESET;
    noise_floor  = NOISE_RESET;
    error_count  = 0;
    results_seen = 0;
    words_sent   = 0;
    gap_pct      = 0;
    idle_cycles  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_light_idle();
    test_random_heavy_idle();
    test_random_back_to_back();

    // drain, then a short tail to catch stray done pulses
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("glyph_bbox_centering_unit verification clean");
    end else begin
      $display("glyph_bbox_centering_unit verification failed");
    end
    $finish;
  end

endmodule
